// ----- rtl/acm_pkg.sv -----
package acm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int ITERS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int ANGLE_FRAC   = 20;
    localparam int DIV_BITS     = 32 + FRAC_BITS;
    localparam int XW           = 37;
    localparam int ZW           = 36;
    localparam int CENTER_COUNT = 2048;

    localparam logic [30:0] BASE_LEN_RST   = 31'd13107;
    localparam logic [30:0] AXLE_WIDTH_RST = 31'd10486;
    localparam logic [11:0] MIN_POS_RST    = 12'd512;
    localparam logic [11:0] MAX_POS_RST    = 12'd3583;

    typedef enum logic [1:0] {
        REG_BASE_LEN   = 2'd0,
        REG_AXLE_WIDTH = 2'd1,
        REG_MIN_POS    = 2'd2,
        REG_MAX_POS    = 2'd3
    } acm_reg_t;

    typedef struct packed {
        logic ang_zero;
        logic ang_neg;
    } acm_meta_t;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/acm_if.sv -----
interface acm_cmd_if;
    logic        valid;
    logic        ready;
    logic [31:0] linear_velocity;
    logic [31:0] angular_velocity;
    modport source (output valid, linear_velocity, angular_velocity, input ready);
    modport sink   (input valid, linear_velocity, angular_velocity, output ready);
endinterface

interface acm_steer_if;
    logic        valid;
    logic        ready;
    logic [11:0] left_steer_position;
    logic [11:0] right_steer_position;
    modport source (output valid, left_steer_position, right_steer_position, input ready);
    modport sink   (input valid, left_steer_position, right_steer_position, output ready);
endinterface

// ----- rtl/acm_div.sv -----
module acm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic signed [31:0]        lin,
    input  logic signed [31:0]        ang,
    output logic                      out_valid,
    output acm_pkg::acm_meta_t        out_meta,
    output logic signed [31:0]        radius
);
    localparam int DW = acm_pkg::DIV_BITS;

    logic                     valid_reg [0:DW];
    logic [DW-1:0]            num_reg   [0:DW];
    logic [31:0]              den_reg   [0:DW];
    logic [31:0]              rem_reg   [0:DW];
    logic [DW-1:0]            q_reg     [0:DW];
    logic                     neg_reg   [0:DW];
    acm_pkg::acm_meta_t       meta_reg  [0:DW];

    logic [31:0]              lin_mag, ang_mag;
    logic                     sat_valid_reg;
    acm_pkg::acm_meta_t       sat_meta_reg;
    logic signed [31:0]       sat_r_reg;
    logic signed [31:0]       sat_r_next;

    assign lin_mag = lin[31] ? (32'd0 - lin) : lin;
    assign ang_mag = ang[31] ? (32'd0 - ang) : ang;

    // Entry: take magnitudes, remember sign of quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg[0]           <= {lin_mag, {acm_pkg::FRAC_BITS{1'b0}}};
            den_reg[0]           <= ang_mag;
            rem_reg[0]           <= '0;
            q_reg[0]             <= '0;
            neg_reg[0]           <= lin[31] ^ ang[31];
            meta_reg[0].ang_zero <= (ang == 32'sd0);
            meta_reg[0].ang_neg  <= ang[31];
        end
    end

    // One quotient bit per stage, restoring
    for (genvar k = 0; k < DW; k++)
    begin : g_step
        logic [32:0] trial;
        logic        ge;
        logic [31:0] rem_next;
        logic [32:0] diff;

        assign trial    = {rem_reg[k], num_reg[k][DW-1]};
        assign ge       = (trial >= {1'b0, den_reg[k]});
        assign diff     = trial - {1'b0, den_reg[k]};
        assign rem_next = ge ? diff[31:0] : trial[31:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[k+1]  <= {num_reg[k][DW-2:0], 1'b0};
                den_reg[k+1]  <= den_reg[k];
                rem_reg[k+1]  <= rem_next;
                q_reg[k+1]    <= {q_reg[k][DW-2:0], ge};
                neg_reg[k+1]  <= neg_reg[k];
                meta_reg[k+1] <= meta_reg[k];
            end
        end
    end

    // Apply sign and saturate to 32 bits
    always_comb
    begin
        if (neg_reg[DW])
        begin
            if (q_reg[DW] > {{(DW-32){1'b0}}, 32'h80000000})
                sat_r_next = 32'sh80000000;
            else
                sat_r_next = 32'sd0 - signed'(q_reg[DW][31:0]);
        end
        else
        begin
            if (q_reg[DW] > {{(DW-32){1'b0}}, 32'h7FFFFFFF})
                sat_r_next = 32'sh7FFFFFFF;
            else
                sat_r_next = signed'(q_reg[DW][31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sat_valid_reg <= valid_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_r_reg    <= sat_r_next;
            sat_meta_reg <= meta_reg[DW];
        end
    end

    assign out_valid = sat_valid_reg;
    assign out_meta  = sat_meta_reg;
    assign radius    = sat_r_reg;

endmodule

// ----- rtl/acm_cordic.sv -----
module acm_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  acm_pkg::acm_meta_t            in_meta,
    input  logic signed [33:0]            x_in,
    input  logic [31:0]                   y_in,
    output logic                          out_valid,
    output acm_pkg::acm_meta_t            out_meta,
    output logic signed [acm_pkg::ZW-1:0] angle
);
    localparam int N  = acm_pkg::ITERS;
    localparam int XW = acm_pkg::XW;
    localparam int ZW = acm_pkg::ZW;

    logic                 valid_reg [0:N];
    logic signed [XW-1:0] x_reg     [0:N];
    logic signed [XW-1:0] y_reg     [0:N];
    logic signed [ZW-1:0] z_reg     [0:N];
    logic                 flat_reg  [0:N];
    logic                 back_reg  [0:N];
    acm_pkg::acm_meta_t   meta_reg  [0:N];

    logic signed [XW-1:0] xe, ye;

    assign xe = XW'(x_in);
    assign ye = signed'({{(XW-32){1'b0}}, y_in});

    // Pre-rotation into the right half plane; flag a zero wheel base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flat_reg[0] <= (y_in == 32'd0);
            back_reg[0] <= x_in[33];
            meta_reg[0] <= in_meta;
            if (x_in[33])
            begin
                x_reg[0] <= ye;
                y_reg[0] <= -xe;
                z_reg[0] <= ZW'(64'sd1 <<< 30);
            end
            else
            begin
                x_reg[0] <= xe;
                y_reg[0] <= ye;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [ZW-1:0] step;
        logic                 pos;

        assign step = signed'({{(ZW-32){1'b0}}, acm_pkg::atan_entry(i)});
        assign pos  = (y_reg[i] > 0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (pos)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + step;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - step;
                end
                flat_reg[i+1] <= flat_reg[i];
                back_reg[i+1] <= back_reg[i];
                meta_reg[i+1] <= meta_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_meta  = meta_reg[N];
    assign angle     = flat_reg[N] ? (back_reg[N] ? ZW'(64'sd1 <<< 31) : '0) : z_reg[N];

endmodule

// ----- rtl/ackermann_steering_angles_unit.sv -----
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds when the output register is full and not taken.
// Stages: 50 for the radius divider (entry, then one quotient bit per stage, then
//   saturate), 1 for the offsets, 17 for the CORDIC pair, 1 to add to centre, 1 to clamp.
// Reset: rst_n clears all valid bits and loads the register defaults.
module ackermann_steering_angles_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    acm_cmd_if.sink     cmd,
    acm_steer_if.source steer
);
    localparam int ZW = acm_pkg::ZW;
    localparam int AF = acm_pkg::ANGLE_FRAC;

    // Configuration registers
    logic [30:0] base_len_reg;
    logic [30:0] axle_width_reg;
    logic [11:0] min_pos_reg;
    logic [11:0] max_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg   <= acm_pkg::BASE_LEN_RST;
            axle_width_reg <= acm_pkg::AXLE_WIDTH_RST;
            min_pos_reg    <= acm_pkg::MIN_POS_RST;
            max_pos_reg    <= acm_pkg::MAX_POS_RST;
        end
        else if (cfg_we)
        begin
            case (acm_pkg::acm_reg_t'(cfg_index))
                acm_pkg::REG_BASE_LEN:   base_len_reg   <= cfg_data;
                acm_pkg::REG_AXLE_WIDTH: axle_width_reg <= cfg_data;
                acm_pkg::REG_MIN_POS:    min_pos_reg    <= cfg_data[11:0];
                acm_pkg::REG_MAX_POS:    max_pos_reg    <= cfg_data[11:0];
                default:                 ;
            endcase
        end
    end

    // Advance everything at once unless a result sits unclaimed
    logic out_valid_reg;
    logic adv;

    assign adv       = !out_valid_reg || steer.ready;
    assign cmd.ready = adv;

    // Turn radius
    logic               div_valid;
    acm_pkg::acm_meta_t div_meta;
    logic signed [31:0] radius;

    acm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cmd.valid),
        .lin       (signed'(cmd.linear_velocity)),
        .ang       (signed'(cmd.angular_velocity)),
        .out_valid (div_valid),
        .out_meta  (div_meta),
        .radius    (radius)
    );

    // Doubled offsets: 2r + aw and 2r - aw, with twice the axle distance as the y leg
    logic                off_valid_reg;
    acm_pkg::acm_meta_t  off_meta_reg;
    logic signed [33:0]  xp_reg, xm_reg;
    logic [31:0]         y_reg;
    logic signed [33:0]  r2, aw;

    assign r2 = {radius[31], radius, 1'b0};
    assign aw = signed'({3'b000, axle_width_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            off_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off_meta_reg <= div_meta;
            xp_reg       <= r2 + aw;
            xm_reg       <= r2 - aw;
            y_reg        <= {base_len_reg, 1'b0};
        end
    end

    // Two angle units: one on the outer offset, one on the inner
    logic                 cp_valid, cm_valid;
    acm_pkg::acm_meta_t   cp_meta, cm_meta;
    logic signed [ZW-1:0] ang_p, ang_m;

    acm_cordic u_cordic_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (off_valid_reg),
        .in_meta   (off_meta_reg),
        .x_in      (xp_reg),
        .y_in      (y_reg),
        .out_valid (cp_valid),
        .out_meta  (cp_meta),
        .angle     (ang_p)
    );

    acm_cordic u_cordic_m (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (off_valid_reg),
        .in_meta   (off_meta_reg),
        .x_in      (xm_reg),
        .y_in      (y_reg),
        .out_valid (cm_valid),
        .out_meta  (cm_meta),
        .angle     (ang_m)
    );

    // Add or subtract from centre by turn direction; both sit at centre when angular velocity is zero
    localparam logic signed [ZW-1:0] CENTER = ZW'(64'(acm_pkg::CENTER_COUNT) <<< AF);

    logic                 sum_valid_reg;
    logic signed [ZW-1:0] lp_reg, rp_reg;
    logic signed [ZW-1:0] lp_next, rp_next;

    always_comb
    begin
        if (cp_meta.ang_zero)
        begin
            lp_next = CENTER;
            rp_next = CENTER;
        end
        else if (cp_meta.ang_neg)
        begin
            lp_next = CENTER - ang_p;
            rp_next = CENTER - ang_m;
        end
        else
        begin
            lp_next = CENTER + ang_m;
            rp_next = CENTER + ang_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sum_valid_reg <= cp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lp_reg <= lp_next;
            rp_reg <= rp_next;
        end
    end

    // Clamp to limits (when crossed, values below the lower limit get it, all others the upper), then drop fraction
    logic signed [ZW-1:0] lo, hi, lc, rc;
    logic [11:0]          left_reg, right_reg;

    assign lo = signed'({{(ZW-12-AF){1'b0}}, min_pos_reg, {AF{1'b0}}});
    assign hi = signed'({{(ZW-12-AF){1'b0}}, max_pos_reg, {AF{1'b0}}});
    assign lc = (lp_reg < lo) ? lo : ((lp_reg > hi) ? hi : lp_reg);
    assign rc = (rp_reg < lo) ? lo : ((rp_reg > hi) ? hi : rp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            left_reg  <= lc[AF+11:AF];
            right_reg <= rc[AF+11:AF];
        end
    end

    assign steer.valid                = out_valid_reg;
    assign steer.left_steer_position  = left_reg;
    assign steer.right_steer_position = right_reg;

`ifndef SYNTHESIS
    a_cordic_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid == cm_valid)
        else $error("angle units out of step");

    a_meta_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid |-> cp_meta == cm_meta)
        else $error("turn flags differ between angle units");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(div_valid) && $stable(sum_valid_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule
